// ----- hdl/period_overlap_day_counter_defines.svh -----
// Assertion macros shared by the period overlap day counter modules.
`ifndef PERIOD_OVERLAP_DAY_COUNTER_DEFINES_SVH
`define PERIOD_OVERLAP_DAY_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF

`define POD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define POD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define POD_ASSERT_IMPL(lbl, ck, rn, ante, cons)

`define POD_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- hdl/podc_pkg.sv -----
// Shared types, constants and calendar functions of the period overlap day counter.
package podc_pkg;

    localparam int DAY_W = 5;
    localparam int MON_W = 4;
    localparam int YEAR_W = 12;
    localparam int YY_W = 13;
    localparam int DN_W = 21;
    localparam int LEN_W = 19;
    localparam int QUEUE_DEPTH = 2;
    localparam int DATE_COUNT = 4;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [YY_W-1:0] YEAR_OFS = 13'd400;
    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;
    localparam logic [YEAR_W-1:0] INV25 = 12'd3113;
    localparam logic [YEAR_W-1:0] INV25_LIMIT = 12'd163;

    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic bad;
        logic [DN_W-1:0] a_start_dn;
        logic [DN_W-1:0] a_end_dn;
        logic [DN_W-1:0] b_start_dn;
        logic [DN_W-1:0] b_end_dn;
    } podc_item_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CALC,
        FRONT_EMIT
    } podc_front_state_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_LEN,
        BACK_SPAN,
        BACK_DONE
    } podc_back_state_t;

    // Days from March 1 to the first of the month, with the year starting in March.
    function automatic logic [8:0] month_offset(input logic [MON_W-1:0] mon);
        logic [8:0] off;
        unique case (mon)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (mon) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [DN_W:0] v);
        logic [LEN_W-1:0] r;
        if (v > (DN_W+1)'(LEN_MAX))
        begin
            r = LEN_MAX;
        end
        else
        begin
            r = v[LEN_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/podc_front.sv -----
// Front end: accepts a transaction, checks the four dates and converts them to day numbers.
`include "period_overlap_day_counter_defines.svh"

module podc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [podc_pkg::DAY_W-1:0]       a_start_day,
    input  logic [podc_pkg::MON_W-1:0]       a_start_month,
    input  logic [podc_pkg::YEAR_W-1:0]      a_start_year,
    input  logic [podc_pkg::DAY_W-1:0]       a_end_day,
    input  logic [podc_pkg::MON_W-1:0]       a_end_month,
    input  logic [podc_pkg::YEAR_W-1:0]      a_end_year,
    input  logic [podc_pkg::DAY_W-1:0]       b_start_day,
    input  logic [podc_pkg::MON_W-1:0]       b_start_month,
    input  logic [podc_pkg::YEAR_W-1:0]      b_start_year,
    input  logic [podc_pkg::DAY_W-1:0]       b_end_day,
    input  logic [podc_pkg::MON_W-1:0]       b_end_month,
    input  logic [podc_pkg::YEAR_W-1:0]      b_end_year,
    output logic                             q_wr,
    output podc_pkg::podc_item_t             q_data,
    input  logic                             q_full
);

    podc_pkg::podc_front_state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       bad_reg, bad_next;

    logic [podc_pkg::DAY_W-1:0]  day_reg  [podc_pkg::DATE_COUNT];
    logic [podc_pkg::MON_W-1:0]  mon_reg  [podc_pkg::DATE_COUNT];
    logic [podc_pkg::YEAR_W-1:0] year_reg [podc_pkg::DATE_COUNT];
    logic [podc_pkg::DN_W-1:0]   dn_reg   [podc_pkg::DATE_COUNT];

    logic [podc_pkg::DN_W-1:0] p365_reg;
    logic [10:0]               q4_reg;
    logic [6:0]                q100_reg;
    logic [4:0]                q400_reg;
    logic [8:0]                doy_reg;

    logic                        accept;
    logic                        calc_en;
    logic                        sum_en;
    logic [1:0]                  sel_idx;
    logic [1:0]                  dn_idx;
    logic [podc_pkg::DAY_W-1:0]  sel_day;
    logic [podc_pkg::MON_W-1:0]  sel_mon;
    logic [podc_pkg::YEAR_W-1:0] sel_year;
    logic [podc_pkg::YY_W-1:0]   yy;
    logic [25:0]                 prod100;
    logic [23:0]                 prod25;
    logic                        div25;
    logic                        leap;
    logic                        date_bad;
    logic [podc_pkg::DN_W-1:0]   p365;
    logic [6:0]                  q100;
    logic [8:0]                  doy;
    logic [podc_pkg::DN_W-1:0]   dn_sum;

    assign sel_idx  = cnt_reg[1:0];
    assign dn_idx   = 2'(cnt_reg - 3'd1);
    assign sel_day  = day_reg[sel_idx];
    assign sel_mon  = mon_reg[sel_idx];
    assign sel_year = year_reg[sel_idx];

    always_comb
    begin
        prod25 = 24'(sel_year) * 24'(podc_pkg::INV25);
        div25  = (prod25[podc_pkg::YEAR_W-1:0] <= podc_pkg::INV25_LIMIT);
        leap   = ((sel_year[1:0] == 2'd0) && !div25) || ((sel_year[3:0] == 4'd0) && div25);
        date_bad = (sel_day == '0) || (sel_mon == '0) || (sel_mon > podc_pkg::MON_DEC)
                   || (sel_day > podc_pkg::month_len(sel_mon, leap));
        yy = podc_pkg::YY_W'(sel_year) + podc_pkg::YEAR_OFS
             - ((sel_mon <= podc_pkg::MON_FEB) ? 13'd1 : 13'd0);
        p365    = podc_pkg::DN_W'(yy) * podc_pkg::DN_W'(podc_pkg::DAYS_PER_YEAR);
        prod100 = 26'(yy) * 26'(podc_pkg::DIV100_MUL);
        q100    = prod100[25:podc_pkg::DIV100_SHIFT];
        doy     = podc_pkg::month_offset(sel_mon) + 9'(sel_day) - 9'd1;
    end

    assign dn_sum = p365_reg + podc_pkg::DN_W'(q4_reg) - podc_pkg::DN_W'(q100_reg)
                    + podc_pkg::DN_W'(q400_reg) + podc_pkg::DN_W'(doy_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        accept     = 1'b0;
        calc_en    = 1'b0;
        sum_en     = 1'b0;
        q_wr       = 1'b0;
        full       = 1'b1;
        unique case (state_reg)
            podc_pkg::FRONT_IDLE:
            begin
                full = 1'b0;
                if (push)
                begin
                    accept     = 1'b1;
                    bad_next   = 1'b0;
                    cnt_next   = 3'd0;
                    state_next = podc_pkg::FRONT_CALC;
                end
            end
            podc_pkg::FRONT_CALC:
            begin
                calc_en  = (cnt_reg < 3'(podc_pkg::DATE_COUNT));
                sum_en   = (cnt_reg != 3'd0);
                cnt_next = cnt_reg + 3'd1;
                if (calc_en)
                begin
                    bad_next = bad_reg | date_bad;
                end
                else
                begin
                    state_next = podc_pkg::FRONT_EMIT;
                end
            end
            podc_pkg::FRONT_EMIT:
            begin
                if (!q_full)
                begin
                    q_wr       = 1'b1;
                    state_next = podc_pkg::FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = podc_pkg::FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= podc_pkg::FRONT_IDLE;
            cnt_reg   <= 3'd0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            day_reg[0]  <= a_start_day;
            mon_reg[0]  <= a_start_month;
            year_reg[0] <= a_start_year;
            day_reg[1]  <= a_end_day;
            mon_reg[1]  <= a_end_month;
            year_reg[1] <= a_end_year;
            day_reg[2]  <= b_start_day;
            mon_reg[2]  <= b_start_month;
            year_reg[2] <= b_start_year;
            day_reg[3]  <= b_end_day;
            mon_reg[3]  <= b_end_month;
            year_reg[3] <= b_end_year;
        end
        if (calc_en)
        begin
            p365_reg <= p365;
            q4_reg   <= yy[podc_pkg::YY_W-1:2];
            q100_reg <= q100;
            q400_reg <= q100[6:2];
            doy_reg  <= doy;
        end
        if (sum_en)
        begin
            dn_reg[dn_idx] <= dn_sum;
        end
    end

    assign q_data.bad        = bad_reg;
    assign q_data.a_start_dn = dn_reg[0];
    assign q_data.a_end_dn   = dn_reg[1];
    assign q_data.b_start_dn = dn_reg[2];
    assign q_data.b_end_dn   = dn_reg[3];

    `POD_ASSERT_NEXT(a_accept_starts_calc, clk, rst_n, push && !full,
                     state_reg == podc_pkg::FRONT_CALC && cnt_reg == 3'd0)
    `POD_ASSERT_IMPL(a_emit_after_all_dates, clk, rst_n, q_wr,
                     cnt_reg == 3'(podc_pkg::DATE_COUNT + 1))

endmodule

// ----- hdl/podc_queue.sv -----
// Short register queue that decouples the front end from the back end.
`include "period_overlap_day_counter_defines.svh"

module podc_queue #(
    parameter int DEPTH = podc_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  podc_pkg::podc_item_t wr_data,
    output logic                 full,
    input  logic                 rd_en,
    output podc_pkg::podc_item_t rd_data,
    output logic                 empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    podc_pkg::podc_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `POD_ASSERT_IMPL(a_no_overflow, clk, rst_n, wr_en, !full || rd_en)
    `POD_ASSERT_IMPL(a_no_underflow, clk, rst_n, rd_en, !empty)

endmodule

// ----- hdl/podc_back.sv -----
// Back end: derives lengths, overlap and overlap count, and holds the result register.
`include "period_overlap_day_counter_defines.svh"

module podc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_rd,
    input  podc_pkg::podc_item_t          q_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [podc_pkg::LEN_W-1:0]    a_length,
    output logic [podc_pkg::LEN_W-1:0]    b_length,
    output logic                          overlaps,
    output logic [podc_pkg::LEN_W-1:0]    overlap_days,
    output logic                          bad_date
);

    podc_pkg::podc_back_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    podc_pkg::podc_item_t      item_reg;
    logic [podc_pkg::DN_W-1:0] la_reg, lb_reg;
    logic                      ov_reg;
    logic [podc_pkg::DN_W:0]   lo_reg, hi_reg;

    logic [podc_pkg::LEN_W-1:0] a_length_reg, b_length_reg, overlap_days_reg;
    logic                       overlaps_reg, bad_date_reg;

    logic                      load_item, len_en, span_en, out_load, out_free;
    logic [podc_pkg::DN_W-1:0] la, lb;
    logic                      ov;
    logic [podc_pkg::DN_W-1:0] ws, we, os, oe;
    logic [podc_pkg::DN_W:0]   lo, hi, oe_inc, span;

    always_comb
    begin
        if (item_reg.a_start_dn < item_reg.a_end_dn)
        begin
            la = item_reg.a_end_dn - item_reg.a_start_dn + 1'b1;
        end
        else
        begin
            la = podc_pkg::DN_W'(1);
        end
        if (item_reg.b_start_dn < item_reg.b_end_dn)
        begin
            lb = item_reg.b_end_dn - item_reg.b_start_dn + 1'b1;
        end
        else
        begin
            lb = podc_pkg::DN_W'(1);
        end
        ov = !((item_reg.b_end_dn < item_reg.a_start_dn)
               || (item_reg.b_start_dn > item_reg.a_end_dn));
    end

    // The shorter period is walked; on a tie the second period is walked.
    always_comb
    begin
        if (la_reg < lb_reg)
        begin
            ws = item_reg.a_start_dn;
            we = item_reg.a_end_dn;
            os = item_reg.b_start_dn;
            oe = item_reg.b_end_dn;
        end
        else
        begin
            ws = item_reg.b_start_dn;
            we = item_reg.b_end_dn;
            os = item_reg.a_start_dn;
            oe = item_reg.a_end_dn;
        end
        oe_inc = (podc_pkg::DN_W+1)'(oe) + 1'b1;
        lo = (podc_pkg::DN_W+1)'((ws > os) ? ws : os);
        hi = ((podc_pkg::DN_W+1)'(we) < oe_inc) ? (podc_pkg::DN_W+1)'(we) : oe_inc;
    end

    assign span     = (ov_reg && (hi_reg > lo_reg)) ? (hi_reg - lo_reg) : '0;
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        load_item  = 1'b0;
        len_en     = 1'b0;
        span_en    = 1'b0;
        out_load   = 1'b0;
        q_rd       = 1'b0;
        unique case (state_reg)
            podc_pkg::BACK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    load_item  = 1'b1;
                    state_next = podc_pkg::BACK_LEN;
                end
            end
            podc_pkg::BACK_LEN:
            begin
                len_en     = 1'b1;
                state_next = podc_pkg::BACK_SPAN;
            end
            podc_pkg::BACK_SPAN:
            begin
                span_en    = 1'b1;
                state_next = podc_pkg::BACK_DONE;
            end
            podc_pkg::BACK_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = podc_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = podc_pkg::BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= podc_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= q_data;
        end
        if (len_en)
        begin
            la_reg <= la;
            lb_reg <= lb;
            ov_reg <= ov;
        end
        if (span_en)
        begin
            lo_reg <= lo;
            hi_reg <= hi;
        end
        if (out_load)
        begin
            bad_date_reg <= item_reg.bad;
            if (item_reg.bad)
            begin
                a_length_reg     <= '0;
                b_length_reg     <= '0;
                overlaps_reg     <= 1'b0;
                overlap_days_reg <= '0;
            end
            else
            begin
                a_length_reg     <= podc_pkg::sat_len((podc_pkg::DN_W+1)'(la_reg));
                b_length_reg     <= podc_pkg::sat_len((podc_pkg::DN_W+1)'(lb_reg));
                overlaps_reg     <= ov_reg;
                overlap_days_reg <= podc_pkg::sat_len(span);
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign a_length     = a_length_reg;
    assign b_length     = b_length_reg;
    assign overlaps     = overlaps_reg;
    assign overlap_days = overlap_days_reg;
    assign bad_date     = bad_date_reg;

    `POD_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_load, !out_valid_reg || pop)
    `POD_ASSERT_IMPL(a_bad_clears_counts, clk, rst_n, out_valid_reg && bad_date_reg,
                     a_length_reg == '0 && b_length_reg == '0 && !overlaps_reg
                     && overlap_days_reg == '0)

endmodule

// ----- hdl/period_overlap_day_counter.sv -----
// Top level of the period overlap day counter.
// Each transaction carries two date periods and yields one result: the inclusive length
// of each period, whether they share a day, and how many days of the shorter period
// (its end day excluded) fall inside the other; any invalid date gives bad_date with
// all counts zero, and counts saturate at the 19-bit maximum. The front end takes a
// new transaction only after handing the last one to the queue, with full high until
// then: its date sequencer loads the four dates, converts them to day numbers in a
// two-stage pipeline and hands the item off to the queue. The back end steps through
// its idle, length, span and done states for each transaction, and a two-entry queue
// between them plus the result register let both sides stall on their own.
// Years 0 to 4095 are all taken as Gregorian.
module period_overlap_day_counter #(
    parameter int QUEUE_DEPTH = podc_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [podc_pkg::DAY_W-1:0]   a_start_day,
    input  logic [podc_pkg::MON_W-1:0]   a_start_month,
    input  logic [podc_pkg::YEAR_W-1:0]  a_start_year,
    input  logic [podc_pkg::DAY_W-1:0]   a_end_day,
    input  logic [podc_pkg::MON_W-1:0]   a_end_month,
    input  logic [podc_pkg::YEAR_W-1:0]  a_end_year,
    input  logic [podc_pkg::DAY_W-1:0]   b_start_day,
    input  logic [podc_pkg::MON_W-1:0]   b_start_month,
    input  logic [podc_pkg::YEAR_W-1:0]  b_start_year,
    input  logic [podc_pkg::DAY_W-1:0]   b_end_day,
    input  logic [podc_pkg::MON_W-1:0]   b_end_month,
    input  logic [podc_pkg::YEAR_W-1:0]  b_end_year,
    output logic                         empty,
    input  logic                         pop,
    output logic [podc_pkg::LEN_W-1:0]   a_length,
    output logic [podc_pkg::LEN_W-1:0]   b_length,
    output logic                         overlaps,
    output logic [podc_pkg::LEN_W-1:0]   overlap_days,
    output logic                         bad_date
);

    logic                 q_wr, q_full, q_rd, q_empty;
    podc_pkg::podc_item_t q_wr_data, q_rd_data;

    podc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .a_start_day   (a_start_day),
        .a_start_month (a_start_month),
        .a_start_year  (a_start_year),
        .a_end_day     (a_end_day),
        .a_end_month   (a_end_month),
        .a_end_year    (a_end_year),
        .b_start_day   (b_start_day),
        .b_start_month (b_start_month),
        .b_start_year  (b_start_year),
        .b_end_day     (b_end_day),
        .b_end_month   (b_end_month),
        .b_end_year    (b_end_year),
        .q_wr          (q_wr),
        .q_data        (q_wr_data),
        .q_full        (q_full)
    );

    podc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    podc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rd         (q_rd),
        .q_data       (q_rd_data),
        .empty        (empty),
        .pop          (pop),
        .a_length     (a_length),
        .b_length     (b_length),
        .overlaps     (overlaps),
        .overlap_days (overlap_days),
        .bad_date     (bad_date)
    );

endmodule
